@@ rtl/core/pc_pkg.sv @@
// Package for the correlation block: item types, snapshot and multiplier
// structs, status codes, sequencer states and width constants. No dependencies.
package pc_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int COUNT_W   = 13;
  localparam int SUM_W     = 29;
  localparam int SQ_W      = 44;
  localparam int CORR_W    = 16;
  localparam int MUL_W     = 64;
  localparam int PROD_W    = 128;
  localparam int ROOT_W    = 144;
  localparam int Q_W       = 15;
  localparam logic [COUNT_W-1:0] MAX_PAIRS = 13'd4096;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_FEW  = 2'd1,
    STATUS_FLAT = 2'd2,
    STATUS_OVF  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CHECK,
    BK_MUL_START,
    BK_MUL_WAIT,
    BK_ROOT_SUM,
    BK_ROOT_CMP,
    BK_FINISH,
    BK_OUT
  } back_state_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x_sample;
    logic signed [SAMPLE_W-1:0] y_sample;
    logic                       last_item;
  } sample_t;

  typedef struct packed {
    logic signed [CORR_W-1:0] correlation;
    logic [1:0]               status;
    logic [COUNT_W-1:0]       sample_count;
  } result_t;

  typedef struct packed {
    logic [COUNT_W-1:0]     count;
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;
    logic [SQ_W-1:0]        sum_xx;
    logic [SQ_W-1:0]        sum_yy;
    logic signed [SQ_W-1:0] sum_xy;
    logic                   overflow;
  } snap_t;

  typedef struct packed {
    logic             start;
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] product;
  } mul_rsp_t;

endpackage

@@ rtl/core/pc_front.sv @@
// Front end: accumulates count and exact sums, one pair per cycle while accept is high.
// Pushes a snapshot of the sums on the last pair. Depends on pc_pkg.
module pc_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  pc_pkg::sample_t sample,
  output logic            push,
  output pc_pkg::snap_t   snap
);

  logic [pc_pkg::COUNT_W-1:0]     count;
  logic signed [pc_pkg::SUM_W-1:0] sum_x;
  logic signed [pc_pkg::SUM_W-1:0] sum_y;
  logic [pc_pkg::SQ_W-1:0]        sum_xx;
  logic [pc_pkg::SQ_W-1:0]        sum_yy;
  logic signed [pc_pkg::SQ_W-1:0] sum_xy;
  logic                           overflow;

  logic signed [2*pc_pkg::SAMPLE_W-1:0] xx;
  logic signed [2*pc_pkg::SAMPLE_W-1:0] yy;
  logic signed [2*pc_pkg::SAMPLE_W-1:0] xy;
  logic                                 full;

  assign xx   = sample.x_sample * sample.x_sample;
  assign yy   = sample.y_sample * sample.y_sample;
  assign xy   = sample.x_sample * sample.y_sample;
  assign full = (count == pc_pkg::MAX_PAIRS);

  // The snapshot already includes the pair being accepted, unless the count is already full.
  always_comb begin
    snap.count    = count;
    snap.sum_x    = sum_x;
    snap.sum_y    = sum_y;
    snap.sum_xx   = sum_xx;
    snap.sum_yy   = sum_yy;
    snap.sum_xy   = sum_xy;
    snap.overflow = overflow | full;
    if (!full) begin
      snap.count  = count + 13'd1;
      snap.sum_x  = sum_x + pc_pkg::SUM_W'(sample.x_sample);
      snap.sum_y  = sum_y + pc_pkg::SUM_W'(sample.y_sample);
      snap.sum_xx = sum_xx + pc_pkg::SQ_W'(unsigned'(xx));
      snap.sum_yy = sum_yy + pc_pkg::SQ_W'(unsigned'(yy));
      snap.sum_xy = sum_xy + pc_pkg::SQ_W'(xy);
    end
  end

  assign push = accept & sample.last_item;

  always_ff @(posedge clk) begin
    if (rst || push) begin
      count    <= '0;
      sum_x    <= '0;
      sum_y    <= '0;
      sum_xx   <= '0;
      sum_yy   <= '0;
      sum_xy   <= '0;
      overflow <= 1'b0;
    end else if (accept) begin
      count    <= snap.count;
      sum_x    <= snap.sum_x;
      sum_y    <= snap.sum_y;
      sum_xx   <= snap.sum_xx;
      sum_yy   <= snap.sum_yy;
      sum_xy   <= snap.sum_xy;
      overflow <= snap.overflow;
    end
  end

endmodule

@@ rtl/core/pc_queue.sv @@
// Two-entry queue of sum snapshots between the front end and the back end.
// Depends on pc_pkg.
module pc_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pc_pkg::snap_t push_snap,
  input  logic          pop,
  output pc_pkg::snap_t head,
  output logic          full,
  output logic          empty
);

  pc_pkg::snap_t slots [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    fill;

  assign full  = (fill == 2'd2);
  assign empty = (fill == 2'd0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_snap;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

@@ rtl/core/pc_mul.sv @@
// Sequential 64 by 64 unsigned multiplier built from four 32 by 32 partial
// products, one per cycle, each added in the next cycle. Depends on pc_pkg.
module pc_mul (
  input  logic             clk,
  input  logic             rst,
  input  pc_pkg::mul_req_t req,
  output pc_pkg::mul_rsp_t rsp
);

  logic [pc_pkg::MUL_W-1:0]  a_r;
  logic [pc_pkg::MUL_W-1:0]  b_r;
  logic [pc_pkg::PROD_W-1:0] acc;
  logic [pc_pkg::MUL_W-1:0]  pp;
  logic [1:0]                pp_idx;
  logic [2:0]                cnt;
  logic                      busy;
  logic                      done;
  logic [31:0]               a_limb;
  logic [31:0]               b_limb;
  logic [pc_pkg::PROD_W-1:0] pp_ext;
  logic [pc_pkg::PROD_W-1:0] pp_shifted;

  assign a_limb = cnt[1] ? a_r[63:32] : a_r[31:0];
  assign b_limb = cnt[0] ? b_r[63:32] : b_r[31:0];
  assign pp_ext = {64'd0, pp};

  always_comb begin
    unique case (pp_idx)
      2'd0:    pp_shifted = pp_ext;
      2'd1:    pp_shifted = pp_ext << 32;
      2'd2:    pp_shifted = pp_ext << 32;
      default: pp_shifted = pp_ext << 64;
    endcase
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r <= req.a;
      b_r <= req.b;
      acc <= '0;
    end else if (busy) begin
      if (cnt != 3'd4) begin
        pp     <= a_limb * b_limb;
        pp_idx <= cnt[1:0];
      end
      if (cnt != 3'd0) begin
        acc <= acc + pp_shifted;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 3'd0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 3'd0;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'd4) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done    = done;
  assign rsp.product = acc;

endmodule

@@ rtl/core/pc_back.sv @@
// Back end: sequencer that forms the variances and covariance with the shared
// multiplier, then finds the Q1.15 ratio bit by bit. Depends on pc_pkg.
module pc_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  pc_pkg::snap_t    head,
  output logic             pop,
  output pc_pkg::mul_req_t mul_req,
  input  pc_pkg::mul_rsp_t mul_rsp,
  output logic             result_valid,
  input  logic             result_stall,
  output pc_pkg::result_t  result
);

  pc_pkg::back_state_t state;
  pc_pkg::back_state_t state_next;
  pc_pkg::snap_t       snap;
  pc_pkg::status_t     status;
  logic [2:0]          step;
  logic [63:0]         vx;
  logic [63:0]         vy;
  logic signed [63:0]  num;
  logic [pc_pkg::PROD_W-1:0] dd;
  logic [pc_pkg::PROD_W-1:0] m0;
  logic [pc_pkg::ROOT_W-1:0] p_acc;
  logic [pc_pkg::ROOT_W-1:0] a_acc;
  logic [pc_pkg::ROOT_W-1:0] e_acc;
  logic [pc_pkg::ROOT_W-1:0] t_sum;
  logic [pc_pkg::Q_W-1:0]    q;
  logic [3:0]                bit_idx;

  logic [pc_pkg::SUM_W-1:0]  sx_mag;
  logic [pc_pkg::SUM_W-1:0]  sy_mag;
  logic [pc_pkg::SQ_W-1:0]   sxy_mag;
  logic [63:0]               p64;
  logic [63:0]               vy_sub;
  logic                      num_neg;
  logic [63:0]               mag;
  logic [pc_pkg::ROOT_W-1:0] m_full;
  logic [16:0]               q_mag;
  logic [pc_pkg::CORR_W-1:0] corr;

  assign sx_mag  = snap.sum_x[pc_pkg::SUM_W-1] ? pc_pkg::SUM_W'(-snap.sum_x)
                                               : pc_pkg::SUM_W'(snap.sum_x);
  assign sy_mag  = snap.sum_y[pc_pkg::SUM_W-1] ? pc_pkg::SUM_W'(-snap.sum_y)
                                               : pc_pkg::SUM_W'(snap.sum_y);
  assign sxy_mag = snap.sum_xy[pc_pkg::SQ_W-1] ? pc_pkg::SQ_W'(-snap.sum_xy)
                                               : pc_pkg::SQ_W'(snap.sum_xy);
  assign p64     = mul_rsp.product[63:0];
  assign vy_sub  = vy - p64;
  assign num_neg = num[63];
  assign mag     = num_neg ? 64'(-num) : 64'(num);
  assign m_full  = pc_pkg::ROOT_W'(m0) << 30;

  // Operands of each product of the sequence.
  always_comb begin
    mul_req.start = (state == pc_pkg::BK_MUL_START);
    unique case (step)
      3'd0: begin
        mul_req.a = 64'(snap.count);
        mul_req.b = 64'(snap.sum_xx);
      end
      3'd1: begin
        mul_req.a = 64'(sx_mag);
        mul_req.b = 64'(sx_mag);
      end
      3'd2: begin
        mul_req.a = 64'(snap.count);
        mul_req.b = 64'(snap.sum_yy);
      end
      3'd3: begin
        mul_req.a = 64'(sy_mag);
        mul_req.b = 64'(sy_mag);
      end
      3'd4: begin
        mul_req.a = 64'(snap.count);
        mul_req.b = 64'(sxy_mag);
      end
      3'd5: begin
        mul_req.a = 64'(sx_mag);
        mul_req.b = 64'(sy_mag);
      end
      3'd6: begin
        mul_req.a = vx;
        mul_req.b = vy;
      end
      default: begin
        mul_req.a = mag;
        mul_req.b = mag;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pc_pkg::BK_IDLE: begin
        if (!q_empty) state_next = pc_pkg::BK_CHECK;
      end
      pc_pkg::BK_CHECK: begin
        if (snap.overflow || snap.count < 13'd2) state_next = pc_pkg::BK_FINISH;
        else state_next = pc_pkg::BK_MUL_START;
      end
      pc_pkg::BK_MUL_START: state_next = pc_pkg::BK_MUL_WAIT;
      pc_pkg::BK_MUL_WAIT: begin
        if (mul_rsp.done) begin
          priority if (step == 3'd3 && (vx == 64'd0 || vy_sub == 64'd0)) begin
            state_next = pc_pkg::BK_FINISH;
          end else if (step == 3'd7) begin
            state_next = pc_pkg::BK_ROOT_SUM;
          end else begin
            state_next = pc_pkg::BK_MUL_START;
          end
        end
      end
      pc_pkg::BK_ROOT_SUM: state_next = pc_pkg::BK_ROOT_CMP;
      pc_pkg::BK_ROOT_CMP: begin
        if (bit_idx == 4'd0) state_next = pc_pkg::BK_FINISH;
        else state_next = pc_pkg::BK_ROOT_SUM;
      end
      pc_pkg::BK_FINISH: state_next = pc_pkg::BK_OUT;
      default: begin
        if (!result_stall) state_next = pc_pkg::BK_IDLE;
      end
    endcase
  end

  always_comb begin
    pop          = (state == pc_pkg::BK_IDLE) && !q_empty;
    result_valid = (state == pc_pkg::BK_OUT);
  end

  // Exactly minus one reaches the most negative code.
  always_comb begin
    if (num_neg && q == 15'h7fff && dd == m0) q_mag = 17'h08000;
    else q_mag = {2'b00, q};
    if (status != pc_pkg::STATUS_OK) corr = '0;
    else if (num_neg) corr = pc_pkg::CORR_W'(17'd0 - q_mag);
    else corr = pc_pkg::CORR_W'(q_mag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pc_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      pc_pkg::BK_IDLE: begin
        if (!q_empty) snap <= head;
      end
      pc_pkg::BK_CHECK: begin
        step <= 3'd0;
        priority if (snap.overflow) status <= pc_pkg::STATUS_OVF;
        else if (snap.count < 13'd2) status <= pc_pkg::STATUS_FEW;
        else status <= pc_pkg::STATUS_OK;
      end
      pc_pkg::BK_MUL_WAIT: begin
        if (mul_rsp.done) begin
          step <= step + 3'd1;
          unique case (step)
            3'd0: vx <= p64;
            3'd1: vx <= vx - p64;
            3'd2: vy <= p64;
            3'd3: begin
              vy <= vy_sub;
              if (vx == 64'd0 || vy_sub == 64'd0) status <= pc_pkg::STATUS_FLAT;
            end
            3'd4: num <= snap.sum_xy[pc_pkg::SQ_W-1] ? -signed'(p64) : signed'(p64);
            3'd5: begin
              if (snap.sum_x[pc_pkg::SUM_W-1] ^ snap.sum_y[pc_pkg::SUM_W-1]) begin
                num <= num + signed'(p64);
              end else begin
                num <= num - signed'(p64);
              end
            end
            3'd6: dd <= mul_rsp.product;
            default: begin
              m0      <= mul_rsp.product;
              p_acc   <= '0;
              a_acc   <= '0;
              e_acc   <= pc_pkg::ROOT_W'(dd) << 28;
              q       <= '0;
              bit_idx <= 4'd14;
            end
          endcase
        end
      end
      pc_pkg::BK_ROOT_SUM: t_sum <= p_acc + a_acc + e_acc;
      pc_pkg::BK_ROOT_CMP: begin
        if (t_sum <= m_full) begin
          p_acc      <= t_sum;
          a_acc      <= (a_acc >> 1) + e_acc;
          q[bit_idx] <= 1'b1;
        end else begin
          a_acc <= a_acc >> 1;
        end
        e_acc   <= e_acc >> 2;
        bit_idx <= bit_idx - 4'd1;
      end
      pc_pkg::BK_FINISH: begin
        result.correlation  <= corr;
        result.status       <= status;
        result.sample_count <= snap.count;
      end
      default: ;
    endcase
  end

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    mul_rsp.done |-> state == pc_pkg::BK_MUL_WAIT)
    else $error("multiplier finished outside its wait state");

  a_root_ends: assert property (@(posedge clk) disable iff (rst)
    (state == pc_pkg::BK_ROOT_CMP && bit_idx == 4'd0) |=> state == pc_pkg::BK_FINISH)
    else $error("root search did not end after its last bit");

  a_ok_needs_two: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status == pc_pkg::STATUS_OK) |-> result.sample_count >= 13'd2)
    else $error("ok status given with fewer than two pairs");

endmodule

@@ rtl/core/pearson_correlation.sv @@
// Top level of the correlation block: front end, snapshot queue, back end
// and shared multiplier. Depends on pc_pkg, pc_front, pc_queue, pc_mul, pc_back.
//
//  Channel  Handshake                   Payload          Direction
//  sample   sample_valid/sample_stall   pc_pkg::sample_t into block
//  result   result_valid/result_stall   pc_pkg::result_t out of block
//
// The front end takes one pair in every cycle that it does not stall; the
// accumulators are updated by a single adder stage per sum.
// A pair marked last pushes its sums into a two-entry queue; the front end
// stalls only while that queue is full.
// The back end handles one series at a time: it pops the snapshot, checks it,
// forms eight products on the shared multiplier, runs the fifteen-bit root
// search with a sum step and a compare step per result bit, registers the
// result and hands it over before it pops the next. Series with too few pairs,
// an overflowed count or a flat series leave the sequence early.
// Reset clears the accumulators, the queue and the sequencer at once; no
// clearing pass follows.
module pearson_correlation (
  input  logic            clk,
  input  logic            rst,
  input  logic            sample_valid,
  output logic            sample_stall,
  input  pc_pkg::sample_t sample,
  output logic            result_valid,
  input  logic            result_stall,
  output pc_pkg::result_t result
);

  logic             accept;
  logic             push;
  pc_pkg::snap_t    push_snap;
  pc_pkg::snap_t    head;
  logic             q_full;
  logic             q_empty;
  logic             pop;
  pc_pkg::mul_req_t mul_req;
  pc_pkg::mul_rsp_t mul_rsp;

  // An item is taken whenever the queue can hold a finished series.
  assign sample_stall = q_full;
  assign accept       = sample_valid & ~sample_stall;

  pc_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .sample (sample),
    .push   (push),
    .snap   (push_snap)
  );

  pc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_snap (push_snap),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  pc_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  pc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .head         (head),
    .pop          (pop),
    .mul_req      (mul_req),
    .mul_rsp      (mul_rsp),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

@@ tb/tb_pearson_correlation.sv @@
// Self-checking testbench for pearson_correlation: directed series, counter overflow
// and random series, each checked against a fixed or predicted result. Depends on pc_pkg.
`timescale 1ns / 100ps

module tb_pearson_correlation;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            sample_valid = 1'b0;
  logic            sample_stall;
  pc_pkg::sample_t sample = '0;
  logic            result_valid;
  logic            result_stall = 1'b1;
  pc_pkg::result_t result;

  pearson_correlation uut (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

  always #6 clk = ~clk;

  // Predictor state: exact sums of the series being gathered.
  int      pairs_held;
  longint  acc_x, acc_y, acc_xx, acc_yy, acc_xy;
  bit      count_full_seen;

  pc_pkg::result_t expected_results[$];
  int      failures = 0;
  int      pairs_sent = 0;
  int      results_seen = 0;
  int      overflow_results = 0;
  int      sender_gap_max = 16;   // zero gives a stretch with no idling
  int      receiver_hold = 0;
  bit      receiver_eager = 1'b0;

  // Largest q in [0, 32767] with q^2 * vx * vy <= mag^2 * 2^30.
  function automatic int unsigned root_quotient(logic [63:0] mag, logic [63:0] vx,
                                                logic [63:0] vy);
    logic [159:0] den, rhs, lhs;
    int unsigned  q, t;
    den = 160'(vx) * 160'(vy);
    rhs = (160'(mag) * 160'(mag)) << 30;
    q = 0;
    for (int b = 14; b >= 0; b--) begin
      t = q | (32'd1 << b);
      lhs = 160'(t) * 160'(t) * den;
      if (lhs <= rhs)
        q = t;
    end
    return q;
  endfunction

  // Adds one pair to the predictor state; on a last pair returns the result it gives.
  function automatic bit accumulate_pair(pc_pkg::sample_t s, output pc_pkg::result_t r);
    longint x, y, vx, vy, num, mag;
    int unsigned q;
    x = longint'(s.x_sample);
    y = longint'(s.y_sample);
    r = '0;
    if (pairs_held >= int'(pc_pkg::MAX_PAIRS)) begin
      count_full_seen = 1'b1;
    end else begin
      pairs_held++;
      acc_x  += x;
      acc_y  += y;
      acc_xx += x * x;
      acc_yy += y * y;
      acc_xy += x * y;
    end
    if (!s.last_item)
      return 1'b0;
    r.sample_count = pc_pkg::COUNT_W'(pairs_held);
    if (count_full_seen) begin
      r.status = pc_pkg::STATUS_OVF;
    end else if (pairs_held < 2) begin
      r.status = pc_pkg::STATUS_FEW;
    end else begin
      vx = pairs_held * acc_xx - acc_x * acc_x;
      vy = pairs_held * acc_yy - acc_y * acc_y;
      if (vx == 0 || vy == 0) begin
        r.status = pc_pkg::STATUS_FLAT;
      end else begin
        r.status = pc_pkg::STATUS_OK;
        num = pairs_held * acc_xy - acc_x * acc_y;
        mag = (num < 0) ? -num : num;
        q = root_quotient(mag, vx, vy);
        if (num < 0) begin
          // An exact anti-correlation reaches the most negative code.
          if (q == 32767 && 160'(vx) * 160'(vy) == 160'(mag) * 160'(mag))
            q = 32768;
          r.correlation = pc_pkg::CORR_W'(-int'(q));
        end else begin
          r.correlation = pc_pkg::CORR_W'(q);
        end
      end
    end
    pairs_held = 0;
    acc_x = 0; acc_y = 0; acc_xx = 0; acc_yy = 0; acc_xy = 0;
    count_full_seen = 1'b0;
    return 1'b1;
  endfunction

  // Drives one pair after a random gap and waits for it to be taken. When a
  // fixed result is given it is queued in place of the predicted one.
  task automatic send_pair(pc_pkg::sample_t s, bit fixed = 1'b0,
                           pc_pkg::result_t fixed_r = '0);
    int              gap;
    pc_pkg::result_t r;
    gap = $urandom_range(0, sender_gap_max);
    if (gap > 0) begin
      sample_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_valid = 1'b1;
    sample = s;
    @(posedge clk);
    while (sample_stall)
      @(posedge clk);
    pairs_sent++;
    if (accumulate_pair(s, r))
      expected_results.push_back(fixed ? fixed_r : r);
    @(negedge clk);
  endtask

  task automatic drop_valid();
    sample_valid = 1'b0;
  endtask

  // Results are taken at the rising edge and compared with the oldest expectation.
  always @(posedge clk) begin
    pc_pkg::result_t want;
    if (!rst && result_valid && !result_stall) begin
      results_seen++;
      if (result.status == pc_pkg::STATUS_OVF)
        overflow_results++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, result);
        failures++;
      end else begin
        want = expected_results.pop_front();
        if (result.correlation !== want.correlation) begin
          $display("%0t: correlation expected %0d actual %0d", $time,
                   want.correlation, result.correlation);
          failures++;
        end
        if (result.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, result.status);
          failures++;
        end
        if (result.sample_count !== want.sample_count) begin
          $display("%0t: sample_count expected %0d actual %0d", $time,
                   want.sample_count, result.sample_count);
          failures++;
        end
      end
      receiver_hold = receiver_eager ? 0 : $urandom_range(0, 16);
    end
  end

  // The receiver stalls for a drawn number of cycles after each item it takes.
  always @(negedge clk) begin
    if (rst) begin
      result_stall = 1'b1;
    end else if (receiver_hold > 0) begin
      result_stall = 1'b1;
      receiver_hold--;
    end else begin
      result_stall = 1'b0;
    end
  end

  typedef struct {
    pc_pkg::sample_t s;
    bit              fixed;
    pc_pkg::result_t r;
  } stim_row_t;

  // Directed series: results that follow at a glance are written in; the rest
  // are left to the predictor.
  stim_row_t directed_rows[] = '{
    '{'{16'sd0, 16'sd0, 1'b1}, 1'b1, '{16'sd0, pc_pkg::STATUS_FEW, 13'd1}},
    '{'{16'sd100, 16'sd200, 1'b0}, 1'b0, '0},
    '{'{16'sd100, 16'sd200, 1'b1}, 1'b1, '{16'sd0, pc_pkg::STATUS_FLAT, 13'd2}},
    '{'{16'sd1, 16'sd1, 1'b0}, 1'b0, '0},
    '{'{16'sd2, 16'sd2, 1'b1}, 1'b1, '{16'sd32767, pc_pkg::STATUS_OK, 13'd2}},
    '{'{16'sd1, -16'sd1, 1'b0}, 1'b0, '0},
    '{'{16'sd2, -16'sd2, 1'b1}, 1'b1, '{-16'sd32768, pc_pkg::STATUS_OK, 13'd2}},
    '{'{-16'sd32768, 16'sd32767, 1'b0}, 1'b0, '0},
    '{'{16'sd32767, -16'sd32768, 1'b1}, 1'b1, '{-16'sd32768, pc_pkg::STATUS_OK, 13'd2}},
    '{'{16'sd32767, 16'sd32767, 1'b0}, 1'b0, '0},
    '{'{-16'sd32768, -16'sd32768, 1'b1}, 1'b1, '{16'sd32767, pc_pkg::STATUS_OK, 13'd2}},
    '{'{16'sd5, -16'sd3, 1'b0}, 1'b0, '0},
    '{'{-16'sd7, 16'sd11, 1'b0}, 1'b0, '0},
    '{'{16'sd300, 16'sd40, 1'b0}, 1'b0, '0},
    '{'{-16'sd1234, 16'sd777, 1'b1}, 1'b0, '0},
    '{'{16'sd32767, 16'sd0, 1'b0}, 1'b0, '0},
    '{'{16'sd0, 16'sd32767, 1'b0}, 1'b0, '0},
    '{'{-16'sd32768, -16'sd1, 1'b1}, 1'b0, '0},
    '{'{16'sd7, -16'sd32768, 1'b0}, 1'b0, '0},
    '{'{16'sd7, 16'sd5, 1'b1}, 1'b1, '{16'sd0, pc_pkg::STATUS_FLAT, 13'd2}}
  };

  // Draws a random series. Most series have a linear link between x and y plus noise,
  // so that the coefficient spreads over its range; some are random or hold x constant.
  task automatic send_random_series();
    int              len, slope, noise, span, kind;
    pc_pkg::sample_t s;
    longint          xv, yv;
    len   = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(2, 14);
    kind  = $urandom_range(0, 9);
    slope = $urandom_range(0, 8) - 4;
    noise = $urandom_range(0, 3) == 0 ? 0 : (1 << $urandom_range(0, 15));
    span  = 1 << $urandom_range(1, 15);
    sender_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 16;
    receiver_eager  = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < len; i++) begin
      if (kind == 0) begin
        s.x_sample = 16'($urandom());
        s.y_sample = 16'($urandom());
      end else begin
        xv = longint'($urandom_range(0, 2 * span - 1)) - span;
        if (kind == 1)
          xv = 123;
        yv = xv * slope + longint'($urandom_range(0, 2 * noise)) - noise;
        if (yv > 32767) yv = 32767;
        if (yv < -32768) yv = -32768;
        if (xv > 32767) xv = 32767;
        s.x_sample = 16'(xv);
        s.y_sample = 16'(yv);
      end
      s.last_item = (i == len - 1);
      send_pair(s);
    end
  endtask

  initial begin
    pc_pkg::sample_t s;
    int              wait_cycles;
    pairs_held = 0;
    acc_x = 0; acc_y = 0; acc_xx = 0; acc_yy = 0; acc_xy = 0;
    count_full_seen = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i])
      send_pair(directed_rows[i].s, directed_rows[i].fixed, directed_rows[i].r);

    // A series of exactly the full count, then one that runs past it: the
    // surplus pairs are dropped and the overflow status wins.
    sender_gap_max = 0;
    for (int n = 0; n < 2 * int'(pc_pkg::MAX_PAIRS) + 2; n++) begin
      s.x_sample  = 16'($urandom());
      s.y_sample  = 16'($urandom());
      s.last_item = (n == int'(pc_pkg::MAX_PAIRS) - 1) ||
                    (n == 2 * int'(pc_pkg::MAX_PAIRS) + 1);
      send_pair(s);
    end

    // Let the back end drain completely before the random series begin.
    drop_valid();
    while (expected_results.size() != 0)
      @(negedge clk);

    while (pairs_sent < 2 * int'(pc_pkg::MAX_PAIRS) + 2 + directed_rows.size() + 450)
      send_random_series();
    drop_valid();
    receiver_eager = 1'b0;

    wait_cycles = 0;
    while (expected_results.size() != 0 && wait_cycles < 100000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (300) @(negedge clk);

    $display("Sent %0d pairs and checked %0d results, %0d of them count overflow.",
             pairs_sent, results_seen, overflow_results);
    if (failures == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d results never arrived", failures,
               expected_results.size());
      $display("status: fail");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #30000000;
    $display("Run limit reached with %0d results outstanding", expected_results.size());
    $display("status: fail");
    $finish;
  end

endmodule
